// ===== hw/rtl/bsw_pkg.sv =====
// ----------------------------------------------------------------------------
// bsw_pkg
// Shared types, constants and table functions of the BMP stream writer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsw_pkg;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

	// Pixel format codes.
	localparam logic [1:0] FMT_MONO = 2'd0;
	localparam logic [1:0] FMT_GRAY = 2'd1;
	localparam logic [1:0] FMT_SEVEN = 2'd2;
	localparam logic [1:0] FMT_SPECTRA = 2'd3;

	// Sizes and defaults.
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DIM_W = 13;
	localparam int ROW_BYTES_W = 12;
	localparam int ROW_PIX_W = 13;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	// Header layout constants.
	localparam logic [6:0] HDR_FIXED_BYTES = 7'd54;
	localparam logic [6:0] OFFSET_MONO = 7'd62;
	localparam logic [6:0] OFFSET_PAL16 = 7'd118;
	localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
	localparam logic [31:0] PELS_PER_METER = 32'd2835;
	localparam logic [31:0] COLORS_MONO = 32'd2;
	localparam logic [31:0] COLORS_PAL16 = 32'd16;

	// Palettes as RGB triplets, one entry after the other.
	localparam logic [7:0] PAL_MONO [0:5] = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};
	localparam logic [7:0] PAL_GRAY [0:11] = '{
		8'd0, 8'd0, 8'd0, 8'd85, 8'd85, 8'd85,
		8'd170, 8'd170, 8'd170, 8'd255, 8'd255, 8'd255};
	localparam logic [7:0] PAL_SEVEN [0:20] = '{
		8'd57, 8'd48, 8'd57, 8'd255, 8'd255, 8'd255, 8'd58, 8'd91, 8'd70,
		8'd61, 8'd59, 8'd94, 8'd156, 8'd72, 8'd75, 8'd208, 8'd190, 8'd71,
		8'd177, 8'd106, 8'd73};
	localparam logic [7:0] PAL_SPECTRA [0:20] = '{
		8'd25, 8'd20, 8'd38, 8'd178, 8'd193, 8'd192, 8'd199, 8'd187, 8'd0,
		8'd107, 8'd17, 8'd25, 8'd255, 8'd255, 8'd255, 8'd24, 8'd83, 8'd154,
		8'd42, 8'd85, 8'd49};

	// One queued job: the bytes that one accepted word turns into.
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       two_data;
		logic [1:0] pad;
		logic       beyond;
	} bsw_job_t;

	// Little-endian byte of a 32-bit value.
	function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] pos);
		logic [7:0] r;
		case (pos)
			2'd0: r = v[7:0];
			2'd1: r = v[15:8];
			2'd2: r = v[23:16];
			default: r = v[31:24];
		endcase
		return r;
	endfunction

	// BGRA palette byte; entries past the palette and the alpha byte are zero.
	function automatic logic [7:0] palette_byte(input logic [1:0] fmt,
		input logic [3:0] entry, input logic [1:0] part);
		logic [3:0] colors;
		logic [4:0] k;
		logic [7:0] r;
		case (fmt)
			FMT_MONO: colors = 4'd2;
			FMT_GRAY: colors = 4'd4;
			default: colors = 4'd7;
		endcase
		k = 5'({2'b00, entry[2:0]} * 5'd3) + (5'd2 - {3'b000, part});
		r = 8'd0;
		if (entry < colors && part != 2'd3) begin
			case (fmt)
				FMT_MONO: r = PAL_MONO[k[2:0]];
				FMT_GRAY: r = PAL_GRAY[k[3:0]];
				FMT_SEVEN: r = PAL_SEVEN[k];
				default: r = PAL_SPECTRA[k];
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bsw_front.sv =====
// ----------------------------------------------------------------------------
// bsw_front
// Holds configuration and row state, accepts input words and turns each one
// into a job descriptor for the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_front #(
	parameter int MAX_WIDTH = bsw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bsw_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             kind,
	input  wire logic [6:0]                       header_index,
	input  wire logic [7:0]                       packed_byte,
	input  wire logic                             row_end,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bsw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bsw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             queue_full,
	output logic                                  push,
	output bsw_pkg::bsw_job_t                     push_job
);
	import bsw_pkg::*;

	logic [1:0]             fmt_q;
	logic [DIM_W-1:0]       width_q;
	logic [DIM_W-1:0]       height_q;
	logic [1:0]             settle_q;
	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic [ROW_PIX_W-1:0]   row_pix_q;

	logic [DIM_W-1:0]       wc;
	logic [DIM_W-1:0]       hc;
	logic [14:0]            row_bits;
	logic [DIM_W-1:0]       padded;
	logic [DIM_W-1:0]       wc_q;
	logic [DIM_W-1:0]       hc_q;
	logic [DIM_W-1:0]       padded_q;
	logic [25:0]            pixels_q;
	logic [26:0]            fsize_q;
	logic [6:0]             offset;

	logic [7:0]             hdr_byte;
	logic [6:0]             rel;
	logic [1:0]             pos;
	logic [3:0]             gp [4];
	logic                   is_gray;
	logic [ROW_BYTES_W-1:0] sent_next;
	logic [13:0]            pix_sum;
	logic [ROW_PIX_W-1:0]   pix_next;
	logic [3:0]             per;

	assign cfg_ready = 1'b1;
	assign in_stall = queue_full || (settle_q != 2'd0);
	assign push = in_valid && !in_stall;
	assign offset = (fmt_q == FMT_MONO) ? OFFSET_MONO : OFFSET_PAL16;
	assign is_gray = (fmt_q == FMT_GRAY);

	// Configuration writes; the input stalls after one while derived values settle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_MONO;
			width_q <= DIM_W'(1);
			height_q <= DIM_W'(1);
			settle_q <= SETTLE_CYCLES;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FORMAT: fmt_q <= cfg_data[1:0];
					REG_WIDTH: width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
				settle_q <= SETTLE_CYCLES;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// Clamp the image size and get the padded row length.
	always_comb begin
		if (width_q == '0) begin
			wc = DIM_W'(1);
		end else if ({2'b00, width_q} > 15'(MAX_WIDTH)) begin
			wc = DIM_W'(MAX_WIDTH);
		end else begin
			wc = width_q;
		end
		if (height_q == '0) begin
			hc = DIM_W'(1);
		end else if ({2'b00, height_q} > 15'(MAX_HEIGHT)) begin
			hc = DIM_W'(MAX_HEIGHT);
		end else begin
			hc = height_q;
		end
		row_bits = (fmt_q == FMT_MONO) ? {2'b00, wc} : {wc, 2'b00};
		padded = DIM_W'(((16'(row_bits) + 16'd31) >> 5) << 2);
	end

	// Derived header values: sizes, then image bytes, then file size.
	always_ff @(posedge clk) begin
		wc_q <= wc;
		hc_q <= hc;
		padded_q <= padded;
		pixels_q <= padded_q * hc_q;
		fsize_q <= 27'(pixels_q) + 27'(offset);
	end

	// Header byte at the requested position.
	always_comb begin
		rel = header_index - HDR_FIXED_BYTES;
		pos = header_index[1:0] - 2'd2;
		unique case (header_index) inside
			7'd0: hdr_byte = 8'h42;
			7'd1: hdr_byte = 8'h4D;
			[7'd2:7'd5]: hdr_byte = le_byte(32'(fsize_q), pos);
			[7'd10:7'd13]: hdr_byte = le_byte(32'(offset), pos);
			[7'd14:7'd17]: hdr_byte = le_byte(INFO_HDR_SIZE, pos);
			[7'd18:7'd21]: hdr_byte = le_byte(32'(wc_q), pos);
			[7'd22:7'd25]: hdr_byte = le_byte(32'd0 - 32'(hc_q), pos);
			7'd26: hdr_byte = 8'd1;
			7'd28: hdr_byte = (fmt_q == FMT_MONO) ? 8'd1 : 8'd4;
			[7'd34:7'd37]: hdr_byte = le_byte(32'(pixels_q), pos);
			[7'd38:7'd45]: hdr_byte = le_byte(PELS_PER_METER, pos);
			[7'd46:7'd49]: hdr_byte = le_byte(
				(fmt_q == FMT_MONO) ? COLORS_MONO : COLORS_PAL16, pos);
			[7'd54:7'd127]: hdr_byte = palette_byte(fmt_q, rel[5:2], rel[1:0]);
			default: hdr_byte = 8'd0;
		endcase
	end

	// Gray pixels past the row width are masked to zero.
	always_comb begin
		for (int p = 0; p < 4; p++) begin
			if (({1'b0, row_pix_q} + 14'(p)) < {1'b0, wc_q}) begin
				gp[p] = {2'b00, packed_byte[6-2*p +: 2]};
			end else begin
				gp[p] = 4'd0;
			end
		end
	end

	// Row bookkeeping for a pixel word.
	always_comb begin
		sent_next = row_bytes_q + (is_gray ? ROW_BYTES_W'(2) : ROW_BYTES_W'(1));
		case (fmt_q)
			FMT_MONO: per = 4'd8;
			FMT_GRAY: per = 4'd4;
			default: per = 4'd2;
		endcase
		pix_sum = {1'b0, row_pix_q} + 14'(per);
		pix_next = pix_sum[13] ? '1 : pix_sum[ROW_PIX_W-1:0];
	end

	// Job descriptor for the queue.
	always_comb begin
		if (!kind) begin
			push_job.beyond = (header_index >= offset);
			push_job.byte0 = push_job.beyond ? 8'd0 : hdr_byte;
			push_job.byte1 = 8'd0;
			push_job.two_data = 1'b0;
			push_job.pad = 2'd0;
		end else begin
			push_job.beyond = 1'b0;
			push_job.byte0 = is_gray ? {gp[0], gp[1]} : packed_byte;
			push_job.byte1 = {gp[2], gp[3]};
			push_job.two_data = is_gray;
			push_job.pad = row_end ? (2'd0 - sent_next[1:0]) : 2'd0;
		end
	end

	// Row state advances on pixel words only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= '0;
			row_pix_q <= '0;
		end else if (push && kind) begin
			if (row_end) begin
				row_bytes_q <= '0;
				row_pix_q <= '0;
			end else begin
				row_bytes_q <= sent_next;
				row_pix_q <= pix_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bsw_fifo.sv =====
// ----------------------------------------------------------------------------
// bsw_fifo
// Short job queue between the front and back parts of the stream writer.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bsw_pkg::bsw_job_t push_job,
	input  wire logic              pop,
	output logic                   full,
	output logic                   nonempty,
	output bsw_pkg::bsw_job_t      head_job
);
	import bsw_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	bsw_job_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;

	assign full = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head_job = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bsw_back.sv =====
// ----------------------------------------------------------------------------
// bsw_back
// Walks the job at the head of the queue, one output word per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              nonempty,
	input  wire bsw_pkg::bsw_job_t head_job,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             out_byte,
	output logic                   run_last,
	output logic                   beyond_header
);
	import bsw_pkg::*;

	logic [2:0] step_q;
	logic [2:0] last_step;
	logic       is_last;
	logic       load;
	logic [7:0] cur_byte;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       beyond_q;

	assign last_step = 3'(head_job.two_data) + 3'(head_job.pad);
	assign is_last = (step_q == last_step);
	assign load = nonempty && (!out_valid_q || !out_stall);
	assign pop = load && is_last;

	// Data bytes first, then padding zeros.
	always_comb begin
		if (step_q == 3'd0) begin
			cur_byte = head_job.byte0;
		end else if (step_q == 3'd1 && head_job.two_data) begin
			cur_byte = head_job.byte1;
		end else begin
			cur_byte = 8'd0;
		end
	end

	// Step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			step_q <= is_last ? 3'd0 : step_q + 3'd1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			run_last_q <= is_last;
			beyond_q <= head_job.beyond;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = run_last_q;
	assign beyond_header = beyond_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bmp_stream_writer.sv =====
// An accepted word passes through the job queue and the output register on its way out.
// The back part gives one output word per cycle while the output is not stalled;
// gray words give two output words, padded row ends up to five, header and other
// pixel words one. After a reset and after each configuration write the input
// stalls while the header sizes and the image byte count are recomputed.
// Reset clears row state, queue and output valid; configuration returns to defaults.
// ----------------------------------------------------------------------------
// bmp_stream_writer
// Top-down paletted BMP byte stream writer: header bytes on request and
// packed pixel bytes expanded and padded per row.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_stream_writer #(
	parameter int MAX_WIDTH = bsw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bsw_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             kind,
	input  wire logic [6:0]                       header_index,
	input  wire logic [7:0]                       packed_byte,
	input  wire logic                             row_end,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [7:0]                            out_byte,
	output logic                                  run_last,
	output logic                                  beyond_header,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bsw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bsw_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bsw_pkg::*;

	logic     push;
	logic     pop;
	logic     queue_full;
	logic     nonempty;
	bsw_job_t push_job;
	bsw_job_t head_job;

	// Front part: configuration, row state and job building.
	bsw_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.header_index(header_index),
		.packed_byte(packed_byte),
		.row_end(row_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.queue_full(queue_full),
		.push(push),
		.push_job(push_job)
	);

	// Job queue.
	bsw_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.full(queue_full),
		.nonempty(nonempty),
		.head_job(head_job)
	);

	// Back part: byte sequencing and output register.
	bsw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.nonempty(nonempty),
		.head_job(head_job),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.beyond_header(beyond_header)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/bsw_checker.sv =====
// ----------------------------------------------------------------------------
// bsw_checker
// Port-level checks of the BMP stream writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_stall,
	input wire logic                             out_valid,
	input wire logic                             out_stall,
	input wire logic [7:0]                       out_byte,
	input wire logic                             run_last,
	input wire logic                             beyond_header,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last)
			&& $stable(beyond_header))
		else $error("stalled output word changed");

	// A header position past the data offset gives a lone zero word.
	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beyond_header |-> out_byte == 8'd0 && run_last)
		else $error("beyond-header word is not a single zero");

	// Input is held off right after a configuration write.
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("input not stalled after configuration write");

	// The words of one run follow without a gap.
	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("gap inside an output run");

endmodule

bind bmp_stream_writer bsw_checker u_bsw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_byte(out_byte),
	.run_last(run_last),
	.beyond_header(beyond_header),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

`default_nettype wire

// ===== verif/bmp_stream_checker.sv =====
// ----------------------------------------------------------------------------
// bmp_stream_checker
// Watches the configuration, input and output channels of the BMP stream
// writer. It keeps its own copy of the settings and the row state, works out
// the bytes that every accepted input word must produce, and compares each
// accepted output word with the oldest of them.
// ----------------------------------------------------------------------------
module bmp_stream_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire logic                             in_stall,
	input  wire logic                             kind,
	input  wire logic [6:0]                       header_index,
	input  wire logic [7:0]                       packed_byte,
	input  wire logic                             row_end,
	input  wire logic                             out_valid,
	input  wire logic                             out_stall,
	input  wire logic [7:0]                       out_byte,
	input  wire logic                             run_last,
	input  wire logic                             beyond_header,
	input  wire logic                             cfg_valid,
	input  wire logic                             cfg_ready,
	input  wire logic [bsw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bsw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                    fail_count,
	output int                                    pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bsw_pkg::*;

	localparam int FILE_HDR_END = int'(HDR_FIXED_BYTES);

	// One output word as it is expected on the output channel.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       beyond;
	} stream_byte_t;

	stream_byte_t expected_bytes[$];

	// Settings and row state as the block should hold them.
	logic [1:0]            fmt_cfg;
	logic [DIM_W-1:0]      width_cfg;
	logic [DIM_W-1:0]      height_cfg;
	logic [ROW_BYTES_W-1:0] row_bytes;
	logic [ROW_PIX_W-1:0]  row_pix;

	function automatic int used_width();
		if (width_cfg == '0)
			return 1;
		if (int'(width_cfg) > DEF_MAX_WIDTH)
			return DEF_MAX_WIDTH;
		return int'(width_cfg);
	endfunction

	function automatic int used_height();
		if (height_cfg == '0)
			return 1;
		if (int'(height_cfg) > DEF_MAX_HEIGHT)
			return DEF_MAX_HEIGHT;
		return int'(height_cfg);
	endfunction

	function automatic int bits_per_pixel();
		return (fmt_cfg == FMT_MONO) ? 1 : 4;
	endfunction

	// Palette size in bytes: two entries for mono, sixteen otherwise.
	function automatic int table_len();
		return (fmt_cfg == FMT_MONO) ? 8 : 64;
	endfunction

	function automatic logic [7:0] lane_byte(input logic [31:0] v, input int pos);
		return 8'(v >> (8 * (pos % 4)));
	endfunction

	// Header byte at a position below the pixel data offset.
	function automatic logic [7:0] header_value(input int idx);
		logic [31:0] data_off;
		logic [31:0] image_bytes;
		int rel;
		int entry;
		int part;
		int colors;
		int k;
		data_off = 32'(FILE_HDR_END + table_len());
		image_bytes = 32'(((used_width() * bits_per_pixel() + 31) / 32) * 4)
			* 32'(used_height());
		if (idx >= FILE_HDR_END) begin
			// BGRA palette; alpha and unused entries are zero.
			rel = idx - FILE_HDR_END;
			entry = rel / 4;
			part = rel % 4;
			colors = (fmt_cfg == FMT_MONO) ? 2 : (fmt_cfg == FMT_GRAY) ? 4 : 7;
			if (entry >= colors || part == 3)
				return 8'h00;
			k = entry * 3 + (2 - part);
			case (fmt_cfg)
				FMT_MONO: return PAL_MONO[k];
				FMT_GRAY: return PAL_GRAY[k];
				FMT_SEVEN: return PAL_SEVEN[k];
				default: return PAL_SPECTRA[k];
			endcase
		end
		if (idx == 0)
			return 8'h42;
		if (idx == 1)
			return 8'h4D;
		if (idx < 6)
			return lane_byte(data_off + image_bytes, idx - 2);
		if (idx < 10)
			return 8'h00;
		if (idx < 14)
			return lane_byte(data_off, idx - 10);
		if (idx < 18)
			return lane_byte(INFO_HDR_SIZE, idx - 14);
		if (idx < 22)
			return lane_byte(32'(used_width()), idx - 18);
		// Height is stored negated so that rows run top-down.
		if (idx < 26)
			return lane_byte(32'd0 - 32'(used_height()), idx - 22);
		if (idx == 26)
			return 8'd1;
		if (idx == 28)
			return 8'(bits_per_pixel());
		if (idx < 34)
			return 8'h00;
		if (idx < 38)
			return lane_byte(image_bytes, idx - 34);
		if (idx < 46)
			return lane_byte(PELS_PER_METER, idx - 38);
		if (idx < 50)
			return lane_byte(32'(table_len() / 4), idx - 46);
		return 8'h00;
	endfunction

	// Gray pixel p of a source byte widened to a nibble; pixels past the
	// row width read as zero.
	function automatic logic [3:0] gray_nibble(input logic [7:0] b, input int p);
		if (int'(row_pix) + p >= used_width())
			return 4'h0;
		return {2'b00, 2'(b >> (6 - 2 * p))};
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Works out the output bytes of one accepted input word.
	task automatic predict_stream_bytes(input logic k, input logic [6:0] idx,
		input logic [7:0] b, input logic re);
		stream_byte_t burst[$];
		int seen;
		if (k == 1'b0) begin
			if (int'(idx) >= FILE_HDR_END + table_len())
				expected_bytes.push_back('{8'h00, 1'b1, 1'b1});
			else
				expected_bytes.push_back('{header_value(int'(idx)), 1'b1, 1'b0});
			return;
		end
		if (fmt_cfg == FMT_GRAY) begin
			burst.push_back('{{gray_nibble(b, 0), gray_nibble(b, 1)}, 1'b0, 1'b0});
			burst.push_back('{{gray_nibble(b, 2), gray_nibble(b, 3)}, 1'b0, 1'b0});
			row_bytes = row_bytes + 12'd2;
		end else begin
			burst.push_back('{b, 1'b0, 1'b0});
			row_bytes = row_bytes + 12'd1;
		end
		// Pixel count saturates rather than wrapping.
		seen = int'(row_pix) + ((fmt_cfg == FMT_MONO) ? 8 : (fmt_cfg == FMT_GRAY) ? 4 : 2);
		row_pix = (seen > 8191) ? '1 : ROW_PIX_W'(seen);
		// Row end pads the output row to a multiple of four bytes.
		if (re) begin
			while (row_bytes[1:0] != 2'd0) begin
				burst.push_back('{8'h00, 1'b0, 1'b0});
				row_bytes = row_bytes + 12'd1;
			end
			row_bytes = '0;
			row_pix = '0;
		end
		burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			expected_bytes.push_back(burst[i]);
	endtask

	task automatic check_output();
		stream_byte_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("unexpected word, byte %02h last %0b beyond %0b",
				out_byte, run_last, beyond_header));
			return;
		end
		want = expected_bytes.pop_front();
		if (out_byte !== want.data)
			report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
		if (run_last !== want.last)
			report_mismatch($sformatf("run_last %0b, expected %0b", run_last, want.last));
		if (beyond_header !== want.beyond)
			report_mismatch($sformatf("beyond_header %0b, expected %0b",
				beyond_header, want.beyond));
	endtask

	// Sample all three channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_cfg = FMT_MONO;
			width_cfg = DIM_W'(1);
			height_cfg = DIM_W'(1);
			row_bytes = '0;
			row_pix = '0;
			expected_bytes.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FORMAT: fmt_cfg = cfg_data[1:0];
					REG_WIDTH: width_cfg = cfg_data;
					REG_HEIGHT: height_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_stream_bytes(kind, header_index, packed_byte, row_end);
			if (out_valid && !out_stall)
				check_output();
		end
		pending = expected_bytes.size();
	end

endmodule

// ===== verif/tb_bmp_stream_writer.sv =====
// ----------------------------------------------------------------------------
// tb_bmp_stream_writer
// Drives the BMP stream writer with header requests and packed pixel rows
// under several formats and image sizes, with random gaps on the input and
// random stalls on the output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_bmp_stream_writer;
	timeunit 1ns;
	timeprecision 1ps;
	import bsw_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    kind = 1'b0;
	logic [6:0]              header_index = '0;
	logic [7:0]              packed_byte = '0;
	logic                    row_end = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [7:0]              out_byte;
	logic                    run_last;
	logic                    beyond_header;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index = REG_FORMAT;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	int fail_count;
	int pending;

	// Idle rates in percent of cycles, and the settings the stimulus shapes rows for.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic [1:0] cur_fmt = FMT_MONO;
	int cur_cols = 1;

	bmp_stream_writer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.header_index(header_index),
		.packed_byte(packed_byte),
		.row_end(row_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.beyond_header(beyond_header),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bmp_stream_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.header_index(header_index),
		.packed_byte(packed_byte),
		.row_end(row_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.beyond_header(beyond_header),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Output stalls change at the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Ends the run when no word moves on any channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Offers one input word, after a random gap, and returns at the falling
	// edge after it was taken. Valid stays high for the next call.
	task automatic send_word(input logic k, input logic [6:0] idx,
		input logic [7:0] b, input logic re);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		header_index <= idx;
		packed_byte <= b;
		row_end <= re;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	// Stops input and waits until every expected byte has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [1:0] fmt, input int w, input int h);
		wait_drained();
		write_reg(REG_FORMAT, CFG_DATA_W'(fmt));
		write_reg(REG_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_HEIGHT, CFG_DATA_W'(h));
		cfg_valid <= 1'b0;
		cur_fmt = fmt;
		cur_cols = (w < 1) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
	endtask

	// Mostly whole source rows with random pixels, mixed with header requests
	// and stray pixel words that end rows at random.
	task automatic random_words(input int count);
		int row_len;
		int pos;
		int roll;
		int n;
		logic last;
		if (cur_fmt == FMT_MONO)
			row_len = (cur_cols + 7) / 8;
		else if (cur_fmt == FMT_GRAY)
			row_len = (cur_cols + 3) / 4;
		else
			row_len = (cur_cols + 1) / 2;
		// Long rows are cut short to keep the run brief.
		if (row_len > 40)
			row_len = $urandom_range(40, 8);
		pos = 0;
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 20) begin
				send_word(1'b0, 7'(($urandom_range(3) == 0) ? $urandom_range(127)
					: $urandom_range(61)), 8'($urandom), 1'($urandom));
			end else if (roll < 28) begin
				last = 1'($urandom);
				send_word(1'b1, 7'($urandom), 8'($urandom), last);
				pos = last ? 0 : pos + 1;
			end else begin
				pos++;
				last = (pos >= row_len) || (n == count - 1);
				send_word(1'b1, 7'($urandom), 8'($urandom), last);
				if (last)
					pos = 0;
			end
		end
	endtask

	initial begin
		tx_idle_pct = 32;
		rx_idle_pct = 77;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: mono, one pixel by one row.
		send_word(1'b0, 7'd0, 8'h00, 1'b0);
		send_word(1'b0, 7'd2, 8'h00, 1'b0);
		send_word(1'b0, 7'd22, 8'h00, 1'b0);
		send_word(1'b0, 7'd28, 8'h00, 1'b0);
		send_word(1'b0, 7'd61, 8'h00, 1'b0);
		send_word(1'b0, 7'd62, 8'h00, 1'b0);
		send_word(1'b0, 7'd127, 8'hFF, 1'b1);
		send_word(1'b1, 7'd127, 8'h00, 1'b0);
		// A header request in the middle of a row leaves the row alone.
		send_word(1'b0, 7'd10, 8'h00, 1'b0);
		send_word(1'b1, 7'd0, 8'hFF, 1'b1);
		// Leave one byte of a row open across the format change.
		send_word(1'b1, 7'd0, 8'hA5, 1'b0);

		// Gray, narrow rows: the first row end closes the row left open in
		// mono, and pixels past the width are masked.
		apply_setting(FMT_GRAY, 5, DEF_MAX_HEIGHT);
		send_word(1'b1, 7'd0, 8'h1B, 1'b1);
		send_word(1'b1, 7'd0, 8'hFF, 1'b0);
		send_word(1'b1, 7'd0, 8'hE4, 1'b1);
		send_word(1'b0, 7'd18, 8'h00, 1'b0);
		send_word(1'b0, 7'd34, 8'h00, 1'b0);
		send_word(1'b0, 7'd117, 8'h00, 1'b0);
		send_word(1'b0, 7'd118, 8'h00, 1'b0);

		apply_setting(FMT_GRAY, 7, 3);
		random_words(50);
		apply_setting(FMT_SEVEN, 13, DEF_MAX_HEIGHT);
		random_words(45);

		// Sender slow, receiver mostly ready; sizes out of range get clamped.
		tx_idle_pct = 77;
		rx_idle_pct = 32;
		apply_setting(FMT_SPECTRA, 0, 8191);
		random_words(30);
		apply_setting(FMT_MONO, 21, 100);
		random_words(45);
		apply_setting(FMT_GRAY, 8191, 0);
		random_words(30);

		// Full rate on both sides.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		apply_setting(FMT_GRAY, 2, 17);
		random_words(45);
		apply_setting(FMT_SPECTRA, 30, 2);
		random_words(40);
		apply_setting(FMT_MONO, DEF_MAX_WIDTH, 1);
		random_words(35);

		wait_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
